FILE: hw/rtl/bitmap_block_allocator_top_assert.svh
// Assertion macros for the bitmap block allocator.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bba: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bba: next-cycle check failed");

`endif

FILE: hw/rtl/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int BLK_W     = 32;  // block number width
  localparam int CNT_W     = 11;  // block count / free count / map index width
  localparam int KIND_W    = 2;
  localparam int WORD_W    = 32;  // map word width
  localparam int BIT_W     = 5;   // bit select within a map word
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY,
    OP_REJECT
  } op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  // Classified request as it travels from front to back.
  typedef struct packed {
    op_e              op;
    logic [CNT_W-1:0] idx;
  } entry_t;

  // Back-end status seen by the front.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

FILE: hw/rtl/bba_front.sv
// Front end: command handshake and request classification (range check).
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_front (
  input  logic                           start,
  output logic                           busy,
  input  logic [bba_pkg::KIND_W-1:0]     kind_i,
  input  logic [bba_pkg::BLK_W-1:0]      block_number_i,
  input  logic [bba_pkg::BLK_W-1:0]      base_i,
  input  logic [bba_pkg::CNT_W-1:0]      n_i,
  input  logic                           q_full_i,
  input  bba_pkg::back_stat_t            stat_i,
  output logic                           push_o,
  output bba_pkg::entry_t                entry_o
);

  logic [bba_pkg::BLK_W-1:0] idx;
  logic                      in_rng;

  always_comb begin
    busy   = q_full_i | stat_i.clearing;
    push_o = start & ~busy;
    // Index wraps modulo 2^32, so numbers below the base land out of range.
    idx    = block_number_i - base_i;
    in_rng = idx < bba_pkg::BLK_W'(n_i);
    entry_o.idx = idx[bba_pkg::CNT_W-1:0];
    case (bba_pkg::kind_e'(kind_i))
      bba_pkg::KIND_ALLOC: entry_o.op = bba_pkg::OP_ALLOC;
      bba_pkg::KIND_FREE:  entry_o.op = in_rng ? bba_pkg::OP_FREE  : bba_pkg::OP_REJECT;
      bba_pkg::KIND_QUERY: entry_o.op = in_rng ? bba_pkg::OP_QUERY : bba_pkg::OP_REJECT;
      default:             entry_o.op = bba_pkg::OP_REJECT;
    endcase
  end

endmodule

FILE: hw/rtl/bba_fifo.sv
// Two-entry request queue between front and back end.
// Depends on bba_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_assert.svh"

module bba_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bba_pkg::entry_t entry_i,
  input  logic            pop_i,
  output bba_pkg::entry_t entry_o,
  output logic            valid_o,
  output logic            full_o
);

  bba_pkg::entry_t              slot_q [bba_pkg::Q_DEPTH];
  logic [bba_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bba_pkg::Q_CNT_W-1:0]  cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == bba_pkg::Q_CNT_W'(bba_pkg::Q_DEPTH);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // The front must hold off while the queue is full.
  `BBA_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full_o, !push_i)

endmodule

FILE: hw/rtl/bba_back.sv
// Back end: free map memory, row summary bits, free counter, clear pass
// and result registers. Depends on bba_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_assert.svh"

module bba_back #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bba_pkg::BLK_W-1:0]   base_i,
  input  logic [bba_pkg::CNT_W-1:0]   n_i,
  input  logic                        clear_i,
  input  logic                        valid_i,
  input  bba_pkg::entry_t             entry_i,
  output logic                        pop_o,
  output bba_pkg::back_stat_t         stat_o,
  output logic                        done_o,
  output logic [bba_pkg::BLK_W-1:0]   alloc_o,
  output bba_pkg::status_e            status_o,
  output logic                        is_free_o,
  output logic [bba_pkg::CNT_W-1:0]   cnt_o
);

  // Only indexes below 2^CNT_W - 1 can ever be in range.
  localparam int CAP   = (MAX_BLOCKS > (2 ** bba_pkg::CNT_W) - 1) ?
                         (2 ** bba_pkg::CNT_W) - 1 : MAX_BLOCKS;
  localparam int ROWS  = (CAP + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                        state_q, state_d;
  logic [ROW_W-1:0]              clr_row_q, clr_row_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [bba_pkg::BIT_W-1:0]     bit_q, bit_d;
  bba_pkg::op_e                  op_q, op_d;
  logic [ROWS-1:0]               sum_q, sum_d;   // row holds a free block
  logic [bba_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [bba_pkg::BLK_W-1:0]     alloc_q, alloc_d;
  bba_pkg::status_e              status_q, status_d;
  logic                          is_free_q, is_free_d;

  logic [bba_pkg::WORD_W-1:0]    map_q [ROWS];
  logic [bba_pkg::WORD_W-1:0]    rd_data_q;
  logic                          rd_en, wr_en;
  logic [ROW_W-1:0]              rd_addr, wr_addr;
  logic [bba_pkg::WORD_W-1:0]    wr_data;

  logic [ROW_W-1:0]              first_row;
  logic                          any_row;
  logic [bba_pkg::BIT_W-1:0]     low_bit;
  logic [bba_pkg::WORD_W-1:0]    bit_mask;
  logic [bba_pkg::WORD_W-1:0]    clr_word;
  logic [bba_pkg::CNT_W-1:0]     clr_idx;

  // Lowest row with a free block.
  always_comb begin
    first_row = '0;
    any_row   = |sum_q;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (sum_q[i]) begin
        first_row = ROW_W'(i);
      end
    end
  end

  // Lowest free bit of the word just read.
  always_comb begin
    low_bit = '0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (rd_data_q[i]) begin
        low_bit = bba_pkg::BIT_W'(i);
      end
    end
  end

  // Clear pass word: only in-range blocks are marked free.
  always_comb begin
    clr_word = '0;
    clr_idx  = '0;
    for (int j = 0; j < bba_pkg::WORD_W; j++) begin
      clr_idx     = bba_pkg::CNT_W'({clr_row_q, bba_pkg::BIT_W'(j)});
      clr_word[j] = clr_idx < n_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    row_d     = row_q;
    bit_d     = bit_q;
    op_d      = op_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    alloc_d   = alloc_q;
    status_d  = status_q;
    is_free_d = is_free_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = row_q;
    wr_en     = 1'b0;
    wr_addr   = row_q;
    wr_data   = rd_data_q;
    bit_mask  = '0;

    if (clear_i) begin
      state_d   = S_CLEAR;
      clr_row_d = '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          wr_en            = 1'b1;
          wr_addr          = clr_row_q;
          wr_data          = clr_word;
          sum_d[clr_row_q] = |clr_word;
          cnt_d            = n_i;
          if (clr_row_q == ROW_W'(ROWS - 1)) begin
            state_d = S_IDLE;
          end else begin
            clr_row_d = clr_row_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (valid_i) begin
            pop_o = 1'b1;
            op_d  = entry_i.op;
            bit_d = entry_i.idx[bba_pkg::BIT_W-1:0];
            case (entry_i.op)
              bba_pkg::OP_ALLOC: begin
                if (any_row) begin
                  rd_en   = 1'b1;
                  rd_addr = first_row;
                  row_d   = first_row;
                  state_d = S_EXEC;
                end else begin
                  done_d    = 1'b1;
                  alloc_d   = '0;
                  status_d  = bba_pkg::ST_NONE_FREE;
                  is_free_d = 1'b0;
                end
              end
              bba_pkg::OP_FREE, bba_pkg::OP_QUERY: begin
                rd_en   = 1'b1;
                rd_addr = entry_i.idx[bba_pkg::BIT_W +: ROW_W];
                row_d   = entry_i.idx[bba_pkg::BIT_W +: ROW_W];
                state_d = S_EXEC;
              end
              default: begin
                done_d    = 1'b1;
                alloc_d   = '0;
                status_d  = bba_pkg::ST_RANGE;
                is_free_d = 1'b0;
              end
            endcase
          end
        end
        S_EXEC: begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          alloc_d   = '0;
          is_free_d = 1'b0;
          status_d  = bba_pkg::ST_OK;
          case (op_q)
            bba_pkg::OP_ALLOC: begin
              bit_mask     = bba_pkg::WORD_W'(1) << low_bit;
              wr_en        = 1'b1;
              wr_data      = rd_data_q & ~bit_mask;
              sum_d[row_q] = |(rd_data_q & ~bit_mask);
              if (cnt_q != '0) begin
                cnt_d = cnt_q - 1'b1;
              end
              alloc_d = base_i + bba_pkg::BLK_W'({row_q, low_bit});
            end
            bba_pkg::OP_FREE: begin
              bit_mask = bba_pkg::WORD_W'(1) << bit_q;
              if (rd_data_q[bit_q]) begin
                status_d = bba_pkg::ST_ALREADY_FREE;
              end else begin
                wr_en        = 1'b1;
                wr_data      = rd_data_q | bit_mask;
                sum_d[row_q] = 1'b1;
                cnt_d        = cnt_q + 1'b1;
              end
            end
            bba_pkg::OP_QUERY: begin
              is_free_d = rd_data_q[bit_q];
            end
            default: begin
              status_d = bba_pkg::ST_RANGE;
            end
          endcase
        end
        default: begin
          state_d   = S_CLEAR;
          clr_row_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= map_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_row_q <= '0;
      row_q     <= '0;
      bit_q     <= '0;
      op_q      <= bba_pkg::OP_REJECT;
      sum_q     <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      alloc_q   <= '0;
      status_q  <= bba_pkg::ST_OK;
      is_free_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
      row_q     <= row_d;
      bit_q     <= bit_d;
      op_q      <= op_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      alloc_q   <= alloc_d;
      status_q  <= status_d;
      is_free_q <= is_free_d;
    end
  end

  assign stat_o.clearing = state_q == S_CLEAR;
  assign done_o          = done_q;
  assign alloc_o         = alloc_q;
  assign status_o        = status_q;
  assign is_free_o       = is_free_q;
  assign cnt_o           = cnt_q;

  // Summary bit said the row had a free block: the word must agree.
  `BBA_ASSERT_IMP(a_sum_match, clk_i, rst_ni, (state_q == S_EXEC) && (op_q == bba_pkg::OP_ALLOC), rd_data_q != '0)
  // Free count never exceeds the managed count once the map is settled.
  `BBA_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, state_q != S_CLEAR, cnt_q <= n_i)
  // Execute is never held: the state moves on in the next cycle.
  `BBA_ASSERT_NXT(a_exec_once, clk_i, rst_ni, state_q == S_EXEC, state_q != S_EXEC)

endmodule

FILE: hw/rtl/bitmap_block_allocator_top.sv
// Top level of the bitmap block allocator: configuration registers and the
// front / queue / back split. Depends on bba_pkg, bba_front, bba_fifo, bba_back.
`timescale 1ns / 1ps

// Bitmap free-list allocator. Commands enter on start while busy is low; each
// command gives exactly one result beat, shown for one cycle with done_o high.
// The receiver cannot stall: results must be taken as they come. A command
// passes a two-entry queue, so start may be given again while earlier work is
// in flight. Allocate and free take one read-modify-write of the map memory
// (32 blocks a word), query a single read: the back end reads the word in its
// idle state and writes it back in its execute state. Commands that need no
// map access (out-of-range free or query, unused kind, allocate with nothing
// free) give their result straight from the idle state. The lowest free block
// is found through one summary bit per map word, so an allocate costs a
// single read. After reset and after every configuration write, a clearing
// pass rewrites the map, one word per cycle; busy stays high meanwhile.
// Configuration writes are always ready and must only be issued while no
// command is outstanding.

module bitmap_block_allocator_top #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [bba_pkg::KIND_W-1:0]      kind_i,
  input  logic [bba_pkg::BLK_W-1:0]       block_number_i,
  // result channel
  output logic                            done_o,
  output logic [bba_pkg::BLK_W-1:0]       allocated_block_o,
  output logic [1:0]                      status_o,
  output logic                            block_is_free_o,
  output logic [bba_pkg::CNT_W-1:0]       free_count_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int CAP = (MAX_BLOCKS > (2 ** bba_pkg::CNT_W) - 1) ?
                       (2 ** bba_pkg::CNT_W) - 1 : MAX_BLOCKS;

  logic [bba_pkg::BLK_W-1:0] base_q;
  logic [bba_pkg::CNT_W-1:0] count_q;
  logic [bba_pkg::CNT_W-1:0] n_eff;
  logic                      cfg_wr;
  logic                      cfg_hit;

  bba_pkg::entry_t     push_entry, q_entry;
  logic                push, pop, q_valid, q_full;
  bba_pkg::back_stat_t back_stat;
  bba_pkg::status_e    status;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  // Only the two defined registers restart the map; other indexes are dropped.
  assign cfg_hit     = cfg_wr & ((cfg_index_i == bba_pkg::CFG_BASE) ||
                                 (cfg_index_i == bba_pkg::CFG_COUNT));

  // Effective count, clipped to the map depth.
  assign n_eff = (count_q > bba_pkg::CNT_W'(CAP)) ? bba_pkg::CNT_W'(CAP) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= bba_pkg::BLK_W'(1);
      count_q <= bba_pkg::CNT_W'(10);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        bba_pkg::CFG_BASE:  base_q  <= cfg_data_i;
        bba_pkg::CFG_COUNT: count_q <= cfg_data_i[bba_pkg::CNT_W-1:0];
        default: begin
          base_q  <= base_q;
          count_q <= count_q;
        end
      endcase
    end
  end

  bba_front u_front (
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .block_number_i (block_number_i),
    .base_i         (base_q),
    .n_i            (n_eff),
    .q_full_i       (q_full),
    .stat_i         (back_stat),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  bba_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (q_entry),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  bba_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .base_i    (base_q),
    .n_i       (n_eff),
    .clear_i   (cfg_hit),
    .valid_i   (q_valid),
    .entry_i   (q_entry),
    .pop_o     (pop),
    .stat_o    (back_stat),
    .done_o    (done_o),
    .alloc_o   (allocated_block_o),
    .status_o  (status),
    .is_free_o (block_is_free_o),
    .cnt_o     (free_count_o)
  );

  assign status_o = status;

endmodule

FILE: tb/bitmap_block_allocator_checker.sv
// Scoreboard for the bitmap block allocator: watches the command, result and
// configuration channels, predicts every result beat and compares it.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bitmap_block_allocator_checker #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [bba_pkg::KIND_W-1:0]    kind_i,
  input  logic [bba_pkg::BLK_W-1:0]     block_number_i,
  input  logic                          done_i,
  input  logic [bba_pkg::BLK_W-1:0]     allocated_block_i,
  input  logic [1:0]                    status_i,
  input  logic                          block_is_free_i,
  input  logic [bba_pkg::CNT_W-1:0]     free_count_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import bba_pkg::*;

  localparam logic [BLK_W-1:0] DEFAULT_BASE  = 32'd1;
  localparam logic [CNT_W-1:0] DEFAULT_COUNT = 11'd10;

  typedef struct packed {
    logic [BLK_W-1:0] block;
    status_e          status;
    logic             is_free;
    logic [CNT_W-1:0] free_count;
  } alloc_result_t;

  bit               free_map [MAX_BLOCKS];
  logic [BLK_W-1:0] base_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] free_left;
  alloc_result_t    awaited_results [$];

  // count register clipped to the map depth
  function automatic int unsigned managed_blocks();
    return (count_q > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_q);
  endfunction

  function automatic void clear_map();
    foreach (free_map[i]) free_map[i] = 1'b1;
    free_left = CNT_W'(managed_blocks());
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == CFG_BASE) begin
      base_q = data;
      clear_map();
    end else if (idx == CFG_COUNT) begin
      count_q = data[CNT_W-1:0];
      clear_map();
    end
  endfunction

  // applies one command to the shadow map and returns its result beat
  function automatic alloc_result_t serve_request(logic [KIND_W-1:0] kind,
                                                  logic [BLK_W-1:0] number);
    alloc_result_t r;
    int unsigned   span;
    logic [BLK_W-1:0] offset;
    span   = managed_blocks();
    offset = number - base_q;
    r      = '{block: '0, status: ST_OK, is_free: 1'b0, free_count: '0};
    case (kind)
      KIND_ALLOC: begin
        r.status = ST_NONE_FREE;
        for (int i = 0; i < span; i++) begin
          if (free_map[i]) begin
            free_map[i] = 1'b0;
            if (free_left != 0) free_left--;
            r.block  = base_q + BLK_W'(i);
            r.status = ST_OK;
            break;
          end
        end
      end
      KIND_FREE: begin
        if (offset >= span) r.status = ST_RANGE;
        else if (free_map[offset]) r.status = ST_ALREADY_FREE;
        else begin
          free_map[offset] = 1'b1;
          free_left++;
        end
      end
      KIND_QUERY: begin
        if (offset >= span) r.status = ST_RANGE;
        else r.is_free = free_map[offset];
      end
      default: r.status = ST_RANGE;
    endcase
    r.free_count = free_left;
    return r;
  endfunction

  function automatic void check_result_beat();
    alloc_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result beat with no command outstanding");
      fail_count_o++;
      return;
    end
    want = awaited_results.pop_front();
    if (allocated_block_i !== want.block) begin
      $error("allocated_block: expected %0d, got %0d", want.block, allocated_block_i);
      fail_count_o++;
    end
    if (status_i !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status_i);
      fail_count_o++;
    end
    if (block_is_free_i !== want.is_free) begin
      $error("block_is_free: expected %0d, got %0d", want.is_free, block_is_free_i);
      fail_count_o++;
    end
    if (free_count_i !== want.free_count) begin
      $error("free_count: expected %0d, got %0d", want.free_count, free_count_i);
      fail_count_o++;
    end
  endfunction

  // beats leave before new commands enter: a result never shares an edge
  // with its own command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  = DEFAULT_BASE;
      count_q = DEFAULT_COUNT;
      clear_map();
      awaited_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (done_i) check_result_beat();
      if (cfg_valid_i && cfg_ready_i) load_register(cfg_index_i, cfg_data_i);
      if (start_i && !busy_i) awaited_results.push_back(serve_request(kind_i, block_number_i));
      pending_o <= awaited_results.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the bitmap block allocator testbench: clock, reset, command and
// configuration stimulus, verdict. Depends on bba_pkg, the allocator RTL and
// bitmap_block_allocator_checker.
`timescale 1ns / 1ps

module testbench;
  import bba_pkg::*;

  localparam int MAP_DEPTH = 1024;
  localparam int N_PHASES  = 12;
  localparam int PHASE_CMDS = 85;

  // codes the package leaves unnamed
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 start = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    kind_i = '0;
  logic [BLK_W-1:0]     block_number_i = '0;
  logic                 done_o;
  logic [BLK_W-1:0]     allocated_block_o;
  logic [1:0]           status_o;
  logic                 block_is_free_o;
  logic [CNT_W-1:0]     free_count_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  int pending;
  int fail_count;

  // stimulus-side view of the current setting, used only to aim block numbers
  logic [BLK_W-1:0] phase_base;
  int unsigned      phase_span;
  int unsigned      allocs_in_phase;
  bit               no_gaps;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bitmap_block_allocator_top #(
    .MAX_BLOCKS(MAP_DEPTH)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .block_number_i    (block_number_i),
    .done_o            (done_o),
    .allocated_block_o (allocated_block_o),
    .status_o          (status_o),
    .block_is_free_o   (block_is_free_o),
    .free_count_o      (free_count_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  bitmap_block_allocator_checker #(
    .MAX_BLOCKS(MAP_DEPTH)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .kind_i            (kind_i),
    .block_number_i    (block_number_i),
    .done_i            (done_o),
    .allocated_block_i (allocated_block_o),
    .status_i          (status_o),
    .block_is_free_i   (block_is_free_o),
    .free_count_i      (free_count_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // Gap between commands: mostly back to back or short, now and then long.
  // A phase with no_gaps set runs flat out.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Free/query target: mostly inside the part of the map that allocates have
  // reached, some on the range edges, the rest anywhere in 32 bits.
  function automatic logic [BLK_W-1:0] pick_block();
    int unsigned r;
    int unsigned span;
    r    = $urandom_range(0, 99);
    span = (allocs_in_phase + 2 < phase_span) ? allocs_in_phase + 2 : phase_span;
    if (r < 70 && span > 0) return phase_base + $urandom_range(0, span - 1);
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return phase_base - 1;
        1:       return phase_base;
        2:       return phase_base + phase_span - 1;
        default: return phase_base + phase_span;
      endcase
    end
    return $urandom();
  endfunction

  // One command beat. start stays high into the next command when no gap
  // follows, so it is never dropped and raised in the same step.
  task automatic send_cmd(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] number);
    int gap;
    start          <= 1'b1;
    kind_i         <= kind;
    block_number_i <= number;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      allocs_in_phase++;
      send_cmd(KIND_ALLOC, $urandom());
    end else if (r < 70) begin
      send_cmd(KIND_FREE, pick_block());
    end else if (r < 95) begin
      send_cmd(KIND_QUERY, pick_block());
    end else begin
      send_cmd(KIND_UNUSED, $urandom());
    end
  endtask

  // Hold off until every outstanding result beat is back. pending is updated
  // at the edge, so the first look comes after the next edge.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after its last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Both registers, in random order; each write restarts the map all free.
  task automatic program_map(logic [BLK_W-1:0] base, logic [CFG_W-1:0] count);
    if ($urandom_range(0, 1)) begin
      cfg_write(CFG_BASE, base);
      cfg_write(CFG_COUNT, count);
    end else begin
      cfg_write(CFG_COUNT, count);
      cfg_write(CFG_BASE, base);
    end
    cfg_valid_i <= 1'b0;
    phase_base      = base;
    phase_span      = (count[CNT_W-1:0] > MAP_DEPTH) ? MAP_DEPTH : count[CNT_W-1:0];
    allocs_in_phase = 0;
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [BLK_W-1:0] new_base;
    logic [CFG_W-1:0] new_count;
    no_gaps = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, at the reset setting (blocks 1..10). The block clears its map
    // first; send_cmd simply waits out busy.
    repeat (10) send_cmd(KIND_ALLOC, '0);      // hands out 1..10
    send_cmd(KIND_ALLOC, 32'hFFFF_FFFF);       // map full: none free
    send_cmd(KIND_QUERY, 32'd0);               // below base
    send_cmd(KIND_QUERY, 32'hFFFF_FFFF);       // far above the range
    send_cmd(KIND_QUERY, 32'd5);               // used
    send_cmd(KIND_FREE, 32'd5);
    send_cmd(KIND_FREE, 32'd5);                // double free
    send_cmd(KIND_QUERY, 32'd5);               // free again
    send_cmd(KIND_FREE, 32'd11);               // one past the last block
    send_cmd(KIND_FREE, 32'd0);                // offset wraps to all ones
    send_cmd(KIND_FREE, 32'hFFFF_FFFF);
    send_cmd(KIND_UNUSED, 32'hFFFF_FFFF);
    send_cmd(KIND_UNUSED, 32'd3);
    send_cmd(KIND_ALLOC, '0);                  // lowest free: 5
    send_cmd(KIND_FREE, 32'd10);               // last block
    send_cmd(KIND_FREE, 32'd1);                // first block
    send_cmd(KIND_ALLOC, '0);                  // back to 1

    // Random phases, each under a fresh setting. The first few pin the
    // extremes: zero base, top of the number space, number wrap, an empty
    // map, and a count above the map depth with upper data bits set.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin new_base = 32'd0;           new_count = 32'd1;           end
        1: begin new_base = 32'hFFFF_FBFF;   new_count = MAP_DEPTH;       end
        2: begin new_base = 32'hFFFF_FFF0;   new_count = 32'd40;          end
        3: begin new_base = $urandom();      new_count = 32'd0;           end
        4: begin new_base = $urandom();      new_count = 32'hFFFF_F7FF;   end
        5: begin new_base = 32'hFFFF_FFFF;   new_count = 32'd1;           end
        default: begin
          new_base  = $urandom();
          new_count = ($urandom_range(0, 9) == 0) ? $urandom_range(65, MAP_DEPTH)
                                                  : $urandom_range(1, 64);
        end
      endcase
      drain();
      program_map(new_base, new_count);
      no_gaps = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_CMDS; n++) begin
        // a write to an unmapped register must leave the map alone
        if (phase == 7 && n == PHASE_CMDS / 2) begin
          drain();
          cfg_write(CFG_SPARE, $urandom());
          cfg_valid_i <= 1'b0;
        end
        if ($urandom_range(0, 49) == 0) drain();
        send_random_cmd();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
